// ===== rtl/hfl_pkg.sv =====
// Shared package for the hash find-or-insert unit.
// Holds fixed field widths, parameter defaults, the state types of both FSMs
// and the result record. No dependencies.
`timescale 1ns / 1ps

package hfl_pkg;

    // Parameter defaults.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    // Fixed port field widths.
    localparam int VERTEX_W   = 32;
    localparam int SLOT_OUT_W = 10;
    localparam int CFG_W      = 11;

    // Table size after reset.
    localparam int CFG_RESET  = 1024;

    // Entries in the queue between the hashing front and the probing back.
    localparam int QUEUE_DEPTH = 2;

    // Front end: accepts a key and reduces it modulo the table size.
    typedef enum logic [1:0] {
        F_IDLE,
        F_DIVIDE,
        F_PUSH
    } t_front_state;

    // Back end: clears occupancy after reset, then probes each slot in a read state and a check state.
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } t_back_state;

    // One result record as driven on the output ports.
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  inserted;
        logic                  table_full;
    } t_result;

    // Status from the probing back end to the top level.
    typedef struct packed {
        logic    clearing;
        logic    done;
        t_result result;
    } t_back_status;

endpackage

// ===== rtl/hfl_front.sv =====
// Front end of the hash unit: takes a key and finds its home slot by a
// bit-serial restoring remainder against the effective table size.
// Depends on hfl_pkg.
`timescale 1ns / 1ps

module hfl_front import hfl_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int SLOT_W    = 10,
    parameter int SIZE_W    = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [VERTEX_W-1:0]  i_vertex_name,
    input  logic [SIZE_W-1:0]    i_eff_size,
    output logic                 o_busy,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic [SLOT_W-1:0]    o_home
);

    localparam int DIV_W = (KEY_WIDTH < VERTEX_W) ? KEY_WIDTH : VERTEX_W;
    localparam int CNT_W = $clog2(DIV_W);

    t_front_state         r_state, n_state;
    logic [KEY_WIDTH-1:0] r_key;
    logic [DIV_W-1:0]     r_dividend;
    logic [SLOT_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [SIZE_W-1:0]    rem_shift;

    // One remainder step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_shift = {r_rem, r_dividend[DIV_W-1]};
        if (rem_shift >= i_eff_size) begin
            n_rem = SLOT_W'(rem_shift - i_eff_size);
        end else begin
            n_rem = SLOT_W'(rem_shift);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_accept) n_state = F_DIVIDE;
            end
            F_DIVIDE: begin
                if (r_cnt == '0) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_busy       = 1'b1;
        o_push_valid = 1'b0;
        unique case (r_state)
            F_IDLE:   o_busy = 1'b0;
            F_DIVIDE: o_busy = 1'b1;
            F_PUSH:   o_push_valid = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Key capture and remainder datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_accept) begin
            r_key      <= KEY_WIDTH'(i_vertex_name);
            r_dividend <= DIV_W'(i_vertex_name);
            r_rem      <= '0;
            r_cnt      <= CNT_W'(DIV_W - 1);
        end else if (r_state == F_DIVIDE) begin
            r_dividend <= r_dividend << 1;
            r_rem      <= n_rem;
            r_cnt      <= r_cnt - CNT_W'(1);
        end
    end

    assign o_key  = r_key;
    assign o_home = r_rem;

endmodule

// ===== rtl/hfl_queue.sv =====
// Two-entry request queue between the hashing front end and the probing back end.
// Carries the key and its home slot. Depends on hfl_pkg.
`timescale 1ns / 1ps

module hfl_queue import hfl_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int SLOT_W    = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [SLOT_W-1:0]    i_home,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic [SLOT_W-1:0]    o_home
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [KEY_WIDTH-1:0] r_key  [QUEUE_DEPTH];
    logic [SLOT_W-1:0]    r_home [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_key        = r_key[r_rd_ptr];
    assign o_home       = r_home[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_key[r_wr_ptr]  <= i_key;
            r_home[r_wr_ptr] <= i_home;
        end
    end

endmodule

// ===== rtl/hfl_back.sv =====
// Probing back end: owns the slot memory (key plus occupied bit), clears it
// after reset, and walks slots linearly from the home slot. Depends on hfl_pkg.
`timescale 1ns / 1ps

module hfl_back import hfl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int SLOT_W      = 10,
    parameter int SIZE_W      = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SIZE_W-1:0]    i_eff_size,
    input  logic                 i_pop_valid,
    output logic                 o_pop_ready,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [SLOT_W-1:0]    i_home,
    output t_back_status         o_status
);

    // Slot memory: bit KEY_WIDTH is the occupied flag.
    logic [KEY_WIDTH:0]   mem [TABLE_DEPTH];
    logic [KEY_WIDTH:0]   r_rd_data;

    t_back_state          r_state, n_state;
    logic [KEY_WIDTH-1:0] r_key;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [SIZE_W-1:0]    r_tries;
    logic [SLOT_W-1:0]    r_clr_addr;
    logic                 r_done;
    t_result              r_result;

    logic                 rd_occupied, key_hit, last_try, clr_last;
    logic [SIZE_W-1:0]    slot_inc, tries_inc;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_addr;
    logic [KEY_WIDTH:0]   mem_wdata;
    logic                 done;
    t_result              result;

    // Probe decisions on the slot just read.
    assign rd_occupied = r_rd_data[KEY_WIDTH];
    assign key_hit     = (r_rd_data[KEY_WIDTH-1:0] == r_key);
    assign tries_inc   = r_tries + SIZE_W'(1);
    assign last_try    = (tries_inc == i_eff_size);
    assign slot_inc    = {1'b0, r_slot} + SIZE_W'(1);
    assign n_slot      = (slot_inc == i_eff_size) ? '0 : SLOT_W'(slot_inc);
    assign clr_last    = (r_clr_addr == SLOT_W'(TABLE_DEPTH - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (clr_last) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_pop_valid) n_state = B_READ;
            end
            B_READ: n_state = B_CHECK;
            B_CHECK: begin
                if (!rd_occupied || key_hit || last_try) n_state = B_IDLE;
                else n_state = B_READ;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // State outputs: memory writes, queue pop and the result.
    always_comb begin
        o_pop_ready         = 1'b0;
        mem_we              = 1'b0;
        mem_addr            = r_slot;
        mem_wdata           = {1'b1, r_key};
        done                = 1'b0;
        result.slot_index   = SLOT_OUT_W'(r_slot);
        result.inserted     = 1'b0;
        result.table_full   = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            B_IDLE: o_pop_ready = 1'b1;
            B_READ: o_pop_ready = 1'b0;
            B_CHECK: begin
                priority if (!rd_occupied) begin
                    // Free slot: claim it for this key.
                    mem_we          = 1'b1;
                    done            = 1'b1;
                    result.inserted = 1'b1;
                end else if (key_hit) begin
                    done = 1'b1;
                end else if (last_try) begin
                    // Every slot in use holds another key.
                    done              = 1'b1;
                    result.slot_index = '0;
                    result.table_full = 1'b1;
                end else begin
                    // Another key sits here: move on to the next slot.
                    done = 1'b0;
                end
            end
            default: o_pop_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= done;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
            end
        end
    end

    // Probe datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_pop_valid) begin
            r_key   <= i_key;
            r_slot  <= i_home;
            r_tries <= '0;
        end else if (r_state == B_CHECK) begin
            r_slot  <= n_slot;
            r_tries <= tries_inc;
        end
        if (done) begin
            r_result <= result;
        end
    end

    // Slot memory write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    // Slot memory read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_slot];
    end

    assign o_status.clearing = (r_state == B_CLEAR);
    assign o_status.done     = r_done;
    assign o_status.result   = r_result;

endmodule

// ===== rtl/hash_find_or_insert_linear_probe_unit.sv =====
// Top level of the find-or-insert hash unit with linear probing.
// Instantiates hfl_front, hfl_queue and hfl_back; depends on hfl_pkg.
`timescale 1ns / 1ps

// Find-or-insert of a key in an open-addressing table with linear probing.
// After reset the unit clears the occupancy of all TABLE_DEPTH slots (1024 by
// default), with busy high; table size writes are taken during that time.
// A key is taken when start is high and busy is low. The front end then runs
// the bit-serial remainder over min(KEY_WIDTH, 32) dividend bits (32 by
// default) that gives the home slot and hands the key over to the queue; it
// takes no new key until that handover is done.
// The back end takes the key from the queue and probes each slot in a read
// state and a check state through the registered read port of the slot
// memory, and the result is registered. A long probe walk stalls the front
// end once the two-entry queue is full. Results appear in key order, each for
// one cycle with o_done high, and cannot be held off. The user must write the
// table size only while the unit is idle; the block itself does not enforce
// this. A size of 0 acts as 1 and sizes above TABLE_DEPTH act as
// TABLE_DEPTH.
module hash_find_or_insert_linear_probe_unit import hfl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VERTEX_W-1:0]   i_vertex_name,
    output logic                  o_done,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic                  o_inserted,
    output logic                  o_table_full,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = SLOT_W + 1;

    logic [SIZE_W-1:0]    r_eff_size;
    logic                 front_busy, start_acc;
    logic                 push_valid, push_ready, pop_valid, pop_ready;
    logic [KEY_WIDTH-1:0] push_key, pop_key;
    logic [SLOT_W-1:0]    push_home, pop_home;
    t_back_status         status;

    // Clamp a written table size into 1..TABLE_DEPTH.
    function automatic logic [SIZE_W-1:0] f_clamp(input logic [CFG_W-1:0] v);
        logic [SIZE_W-1:0] s;
        if (32'(v) > 32'(TABLE_DEPTH)) begin
            s = SIZE_W'(TABLE_DEPTH);
        end else if (v == '0) begin
            s = SIZE_W'(1);
        end else begin
            s = SIZE_W'(v);
        end
        return s;
    endfunction

    // Effective table size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_size <= f_clamp(CFG_W'(CFG_RESET));
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eff_size <= f_clamp(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = front_busy || status.clearing;
    assign start_acc   = start && !busy;

    hfl_front #(
        .KEY_WIDTH (KEY_WIDTH),
        .SLOT_W    (SLOT_W),
        .SIZE_W    (SIZE_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start_acc),
        .i_vertex_name (i_vertex_name),
        .i_eff_size    (r_eff_size),
        .o_busy        (front_busy),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_key         (push_key),
        .o_home        (push_home)
    );

    hfl_queue #(
        .KEY_WIDTH (KEY_WIDTH),
        .SLOT_W    (SLOT_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_key        (push_key),
        .i_home       (push_home),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_key        (pop_key),
        .o_home       (pop_home)
    );

    hfl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .SLOT_W      (SLOT_W),
        .SIZE_W      (SIZE_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_size  (r_eff_size),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_key       (pop_key),
        .i_home      (pop_home),
        .o_status    (status)
    );

    assign o_done       = status.done;
    assign o_slot_index = status.result.slot_index;
    assign o_inserted   = status.result.inserted;
    assign o_table_full = status.result.table_full;

    // No result can appear while the slot memory is being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.clearing |-> !o_done)
        else $error("result strobe during clearing pass");

    // Leaving reset starts the clearing pass, so the unit must report busy.
    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> busy)
        else $error("not busy right after reset");

    // An accepted request keeps the unit busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("not busy after an accepted request");

    // A full-table result carries no slot and no insert.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_table_full |-> !o_inserted && o_slot_index == '0)
        else $error("full result with slot or insert set");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the linear-probe find-or-insert hash unit.
// Predicts every slot, inserted and full result from its own copy of the table.
// Depends on rtl/hfl_pkg.sv and rtl/hash_find_or_insert_linear_probe_unit.sv.
`timescale 1ns / 1ps

module tb_top;
    import hfl_pkg::*;

    localparam int SLOT_COUNT   = TABLE_DEPTH_DEF;
    localparam int PHASE_COUNT  = 11;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_LIMIT  = 25000;
    localparam int DRAIN_TAIL   = 100;
    localparam int REPORT_LIMIT = 10;

    // Mirror of the slot table with the queue of results still owed by the unit.
    class slot_table_checker;
        logic [VERTEX_W-1:0] slot_key [SLOT_COUNT];
        bit                  slot_used [SLOT_COUNT];
        logic [CFG_W-1:0]    size_reg;
        t_result             expected_q [$];
        int unsigned         mismatches;

        function new();
            size_reg   = CFG_W'(CFG_RESET);
            mismatches = 0;
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
            end
        endfunction

        function void set_size(logic [CFG_W-1:0] value);
            size_reg = value;
        endfunction

        // Slots actually probed: zero acts as one, oversize clamps to the depth.
        function int unsigned span();
            if (size_reg == 0) begin
                return 1;
            end
            if (size_reg > SLOT_COUNT) begin
                return SLOT_COUNT;
            end
            return size_reg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Walks the table for an accepted request and queues the outcome.
        function void note_key(logic [VERTEX_W-1:0] key);
            int unsigned limit;
            int unsigned slot;
            int unsigned tries;
            t_result     outcome;
            limit = span();
            slot = key % limit;
            outcome = '0;
            outcome.table_full = 1'b1;
            for (tries = 0; tries < limit; tries++) begin
                if (!slot_used[slot]) begin
                    slot_used[slot] = 1'b1;
                    slot_key[slot] = key;
                    outcome.slot_index = SLOT_OUT_W'(slot);
                    outcome.inserted = 1'b1;
                    outcome.table_full = 1'b0;
                    break;
                end
                if (slot_key[slot] == key) begin
                    outcome.slot_index = SLOT_OUT_W'(slot);
                    outcome.table_full = 1'b0;
                    break;
                end
                slot = (slot + 1 == limit) ? 0 : slot + 1;
            end
            expected_q.push_back(outcome);
        endfunction

        // Compares one result from the unit with the oldest outstanding one.
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("ERROR: result with no request outstanding: slot %0d ins %0b full %0b",
                             got.slot_index, got.inserted, got.table_full);
                end
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.slot_index !== want.slot_index || got.inserted !== want.inserted ||
                    got.table_full !== want.table_full) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("ERROR: expected slot %0d ins %0b full %0b, got slot %0d ins %0b full %0b",
                             want.slot_index, want.inserted, want.table_full,
                             got.slot_index, got.inserted, got.table_full);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [VERTEX_W-1:0]   i_vertex_name = '0;
    logic                  o_done;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic                  o_inserted;
    logic                  o_table_full;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    slot_table_checker   table_chk = new();
    logic [VERTEX_W-1:0] key_pool [$];
    int unsigned         quiet_cycles = 0;

    hash_find_or_insert_linear_probe_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_vertex_name (i_vertex_name),
        .o_done        (o_done),
        .o_slot_index  (o_slot_index),
        .o_inserted    (o_inserted),
        .o_table_full  (o_table_full),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Every strobed result is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            table_chk.check_result('{o_slot_index, o_inserted, o_table_full});
        end
    end

    // Ends the run as failed when no request, result or size write has been seen for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one key and holds it until the unit takes the request.
    task automatic send_key(input logic [VERTEX_W-1:0] key);
        start <= 1'b1;
        i_vertex_name <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        table_chk.note_key(key);
        key_pool.push_back(key);
    endtask

    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        while (table_chk.pending() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        table_chk.set_size(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly small tables, with the full depth, oversize and zero now and then.
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return CFG_W'(SLOT_COUNT);
            1: return CFG_W'($urandom_range(SLOT_COUNT + 1, (1 << CFG_W) - 1));
            2: return '0;
            3: return CFG_W'(1);
            4, 5: return CFG_W'($urandom_range(2, 16));
            6, 7: return CFG_W'($urandom_range(17, 128));
            default: return CFG_W'($urandom_range(129, SLOT_COUNT - 1));
        endcase
    endfunction

    // Repeats of earlier keys give hits; keys homing near a slot multiple build clusters.
    function automatic logic [VERTEX_W-1:0] pick_key(input int unsigned limit);
        int unsigned         roll;
        logic [VERTEX_W-1:0] key;
        roll = $urandom_range(0, 99);
        key = $urandom;
        if (roll < 45 && key_pool.size() != 0) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (roll < 60) begin
            key = key - key % limit + $urandom_range(0, 3);
        end else if (roll < 63) begin
            key = '1;
        end else if (roll < 65) begin
            key = '0;
        end
        return key;
    endfunction

    initial begin
        int unsigned idle_pct;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full depth: extreme keys, a wrap from the last slot, collisions and hits.
        write_size(CFG_W'(SLOT_COUNT));
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'd1023);
        send_key(32'd1024);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);

        // Size zero behaves as one slot, which already holds key zero.
        drain();
        write_size('0);
        send_key(32'h0000_0000);
        send_key(32'd5);

        // Oversize clamps to the depth; the upper entries are visible again.
        drain();
        write_size('1);
        send_key(32'hFFFF_FFFF);
        pause(3);
        send_key(32'h8000_0001);

        // Three slots, all taken: a miss is full, an old key is still found.
        drain();
        write_size(CFG_W'(3));
        send_key(32'd7);
        send_key(32'd1024);
        send_key(32'hAAAA_5555);

        drain();
        write_size(CFG_W'(1));
        send_key(32'h0000_0000);
        send_key(32'h5555_AAAA);

        // Random phases, each at its own table size; the last one runs without gaps.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain();
            write_size(pick_size());
            idle_pct = (ph == PHASE_COUNT - 1) ? 0 : $urandom_range(0, 60);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_key(pick_key(table_chk.span()));
                if ($urandom_range(1, 100) <= idle_pct) begin
                    pause($urandom_range(1, 13));
                end
            end
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (table_chk.mismatches == 0 && table_chk.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== hash_find_or_insert_linear_probe_unit.f =====
rtl/hfl_pkg.sv
rtl/hfl_front.sv
rtl/hfl_queue.sv
rtl/hfl_back.sv
rtl/hash_find_or_insert_linear_probe_unit.sv
tb/tb_top.sv
